// ===== rtl/core/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg: shared types and constants for the MIDI clock tracker
// Beat payload structs, command and mode codes, run states and the
// modulo-six helper used for the 16th pulse.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

   // Width of the wrapping step counters (8 to 16)
   localparam int CNT_W    = 8;
   localparam int STAMP_W  = 16;
   localparam int WEIGHT_W = 9;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = WEIGHT_W'(256);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(220);
   localparam logic [STAMP_W-1:0]  BASE_RESET   = STAMP_W'(1286);
   localparam int PHASE_SHIFT  = 4;   // elapsed time / 16
   localparam int BLEND_SHIFT  = 8;   // weights out of 256

   // Commands
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_EXT_CLOCK  = 3'd1;
   localparam logic [2:0] CMD_EXT_START  = 3'd2;
   localparam logic [2:0] CMD_EXT_STOP   = 3'd3;
   localparam logic [2:0] CMD_INT_START  = 3'd4;
   localparam logic [2:0] CMD_INT_STOP   = 3'd5;
   localparam logic [2:0] CMD_INT_PAUSE  = 3'd6;

   // Clock modes
   localparam logic [1:0] MODE_INTERNAL = 2'd1;
   localparam logic [1:0] MODE_EXTERNAL = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CLOCK_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TX_ENABLE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLL_WEIGHT    = 2'd3;

   // MIDI realtime bytes
   localparam logic [7:0] BYTE_CLOCK = 8'hF8;
   localparam logic [7:0] BYTE_START = 8'hFA;
   localparam logic [7:0] BYTE_STOP  = 8'hFC;
   localparam logic [7:0] BYTE_NONE  = 8'h00;

   typedef enum logic [1:0] {
      RUN_PAUSED   = 2'd0,
      RUN_STARTING = 2'd1,
      RUN_STARTED  = 2'd2
   } run_state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [STAMP_W-1:0] timestamp;
   } req_beat_type;

   typedef struct packed {
      logic               pulse_96th;
      logic               pulse_16th;
      logic               send_valid;
      logic [7:0]         send_byte;
      logic [1:0]         run_status;
      logic [STAMP_W-1:0] beat_interval;
   } rsp_beat_type;

   localparam int CNT_DIGITS = (CNT_W + 1) / 2;

   // x mod 6 == 1: x odd and x mod 3 == 1. Base-4 digits each count once
   // mod 3, so a running sum of digits folded below 3 gives x mod 3.
   function automatic logic is_mod6_one(input logic [CNT_W-1:0] x);
      logic [2*CNT_DIGITS-1:0] xe;
      logic [2:0]              acc;
      xe  = (2*CNT_DIGITS)'(x);
      acc = 3'd0;
      for (int i = 0; i < CNT_DIGITS; i++) begin
         acc = acc + {1'b0, xe[2*i +: 2]};
         if (acc >= 3'd3) begin
            acc = acc - 3'd3;
         end
      end
      return x[0] && (acc == 3'd1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/midi_clock_tracker_core.sv =====
// ----------------------------------------------------------------------------
// midi_clock_tracker_core: MIDI clock generator and follower
// Pipeline: the req beat is captured in the input register, then one pass
//   of update logic fills the result register once that one is free or
//   drains; rsp_stall can hold the beat in the input register in between.
// Throughput: one beat per cycle while rsp_stall is low; the single-pass
//   update of the tracker state sets this, and an empty input register lets
//   a new beat in while a finished one waits on rsp_stall.
// Reset: synchronous, active high; clears control state, loads interval
//   estimate with 1286 and the smoothing weight with 220. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_clock_tracker_core
   import mct_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_beat_type         req_data,
   // response channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_beat_type         rsp_data,
   // configuration
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]          clock_mode_ff,   clock_mode_in;
   logic                tx_enable_ff,    tx_enable_in;
   logic [WEIGHT_W-1:0] pll_weight_ff,   pll_weight_in;

   // ---------------------------------------------------------------------
   // Tracker state
   // ---------------------------------------------------------------------
   run_state_type       run_state_ff,    run_state_in;
   logic [STAMP_W-1:0]  countdown_ff,    countdown_in;
   logic [STAMP_W-1:0]  last_stamp_ff,   last_stamp_in;
   logic [STAMP_W-1:0]  interval_ff,     interval_in;
   logic [CNT_W-1:0]    out_count_ff,    out_count_in;
   logic [CNT_W-1:0]    in_count_ff,     in_count_in;

   // ---------------------------------------------------------------------
   // Pipeline: input register, result register
   // ---------------------------------------------------------------------
   logic                stg_valid_ff,    stg_valid_in;
   req_beat_type        stg_data_ff,     stg_data_in;
   logic                rsp_valid_ff,    rsp_valid_in;
   rsp_beat_type        rsp_data_ff,     rsp_data_in;

   logic                advance;

   // Stage moves into the result register when that one is free or drains.
   assign advance      = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = stg_valid_ff && !advance;
   assign stg_valid_in = (req_valid && !req_stall) || (stg_valid_ff && !advance);
   assign stg_data_in  = (req_valid && !req_stall) ? req_data : stg_data_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Datapath pieces that do not depend on the command
   // ---------------------------------------------------------------------
   logic [STAMP_W-1:0]            elapsed;
   logic [WEIGHT_W-1:0]           weight_sat;
   logic [WEIGHT_W-1:0]           weight_new;
   logic [STAMP_W+WEIGHT_W-1:0]   blend_old;
   logic [STAMP_W+WEIGHT_W-1:0]   blend_new;
   logic [STAMP_W+WEIGHT_W-1:0]   blend_sum;
   logic [STAMP_W-1:0]            blended;
   logic [CNT_W-1:0]              in_count_inc;

   // Elapsed time since the last external clock, wraps at 65536
   assign elapsed    = stg_data_ff.timestamp - last_stamp_ff;
   assign weight_sat = (pll_weight_ff > WEIGHT_FULL) ? WEIGHT_FULL : pll_weight_ff;
   assign weight_new = WEIGHT_FULL - weight_sat;
   // Two independent 16x9 products, then one add
   assign blend_old  = interval_ff * weight_sat;
   assign blend_new  = elapsed * weight_new;
   assign blend_sum  = blend_old + blend_new;
   assign blended    = blend_sum[BLEND_SHIFT +: STAMP_W];
   assign in_count_inc = in_count_ff + CNT_W'(1);

   // Tick path: counter step, resync to input count, phase correction
   logic [CNT_W-1:0]   out_count_inc;
   logic [CNT_W:0]     in_count_next;
   logic               resync;
   logic [CNT_W-1:0]   out_count_tick;
   logic [STAMP_W-1:0] pull_amount;
   logic [STAMP_W-1:0] pulled;
   logic [STAMP_W-1:0] push_amount;
   logic [STAMP_W:0]   push_sum;
   logic [STAMP_W-1:0] pushed;
   logic [STAMP_W-1:0] reload_ext;

   assign out_count_inc  = out_count_ff + CNT_W'(1);
   assign in_count_next  = {1'b0, in_count_ff} + (CNT_W+1)'(1);
   assign resync         = (out_count_inc < in_count_ff)
                        || ({1'b0, out_count_inc} > in_count_next);
   assign out_count_tick = resync ? in_count_ff : out_count_inc;

   // Behind the source: pull the reload earlier by elapsed/16, floor at 0
   assign pull_amount = elapsed >> PHASE_SHIFT;
   assign pulled      = (interval_ff > pull_amount) ? interval_ff - pull_amount
                                                    : '0;
   // One step ahead: stretch the reload, saturate at full scale
   assign push_amount = (interval_ff - elapsed) >> PHASE_SHIFT;
   assign push_sum    = {1'b0, interval_ff} + {1'b0, push_amount};
   assign pushed      = push_sum[STAMP_W] ? '1 : push_sum[STAMP_W-1:0];

   always_comb begin
      if (out_count_tick <= in_count_ff) begin
         reload_ext = pulled;
      end else if (interval_ff > elapsed) begin
         reload_ext = pushed;
      end else begin
         reload_ext = interval_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Per-beat update and result
   // ---------------------------------------------------------------------
   logic       pulse_96th;
   logic       pulse_16th;
   logic       send_valid;
   logic [7:0] send_byte;
   logic       int_mode;
   logic       ext_mode;

   assign int_mode = (clock_mode_ff == MODE_INTERNAL);
   assign ext_mode = (clock_mode_ff == MODE_EXTERNAL);

   always_comb begin
      clock_mode_in = clock_mode_ff;
      tx_enable_in  = tx_enable_ff;
      pll_weight_in = pll_weight_ff;
      run_state_in  = run_state_ff;
      countdown_in  = countdown_ff;
      last_stamp_in = last_stamp_ff;
      interval_in   = interval_ff;
      out_count_in  = out_count_ff;
      in_count_in   = in_count_ff;
      pulse_96th    = 1'b0;
      pulse_16th    = 1'b0;
      send_valid    = 1'b0;
      send_byte     = BYTE_NONE;

      if (advance) begin
         case (stg_data_ff.command)
            CMD_TICK: begin
               if (countdown_ff != '0) begin
                  countdown_in = countdown_ff - STAMP_W'(1);
               end else begin
                  pulse_96th = 1'b1;
                  if (ext_mode) begin
                     out_count_in = out_count_tick;
                     countdown_in = reload_ext;
                     pulse_16th   = is_mod6_one(out_count_tick);
                  end else begin
                     out_count_in = out_count_inc;
                     countdown_in = interval_ff;
                     pulse_16th   = is_mod6_one(out_count_inc);
                     if (int_mode && tx_enable_ff) begin
                        send_valid = 1'b1;
                        send_byte  = BYTE_CLOCK;
                     end
                  end
               end
            end
            CMD_EXT_CLOCK: begin
               // measured in every mode
               last_stamp_in = stg_data_ff.timestamp;
               in_count_in   = in_count_inc;
               if (run_state_ff == RUN_STARTING) begin
                  run_state_in = RUN_STARTED;
               end else if (run_state_ff == RUN_STARTED) begin
                  // an input count of 2 takes the raw period, later clocks blend
                  interval_in = (in_count_inc == CNT_W'(2)) ? elapsed : blended;
               end
            end
            CMD_EXT_START: begin
               if (ext_mode) begin
                  pll_weight_in = WEIGHT_RESET;
                  countdown_in  = '0;
                  last_stamp_in = '0;
                  out_count_in  = '0;
                  in_count_in   = '0;
                  run_state_in  = RUN_STARTING;
               end
            end
            CMD_EXT_STOP: begin
               if (ext_mode) begin
                  run_state_in = RUN_PAUSED;
               end
            end
            CMD_INT_START, CMD_INT_STOP, CMD_INT_PAUSE: begin
               if (int_mode) begin
                  if (stg_data_ff.command == CMD_INT_START
                      || (stg_data_ff.command == CMD_INT_PAUSE
                          && run_state_ff == RUN_PAUSED)) begin
                     run_state_in = RUN_STARTED;
                     out_count_in = '0;
                     send_byte    = tx_enable_ff ? BYTE_START : BYTE_NONE;
                  end else begin
                     run_state_in = RUN_PAUSED;
                     send_byte    = tx_enable_ff ? BYTE_STOP : BYTE_NONE;
                  end
                  send_valid = tx_enable_ff;
               end
            end
            default: begin
               // unused command: report state only
            end
         endcase
      end

      // Register writes are to arrive only while the block is idle; the block itself does not enforce this.
      if (csr_write_en) begin
         case (csr_index)
            REG_CLOCK_MODE:    clock_mode_in = csr_wdata[1:0];
            REG_TX_ENABLE:     tx_enable_in  = csr_wdata[0];
            REG_BASE_INTERVAL: interval_in   = csr_wdata[STAMP_W-1:0];
            REG_PLL_WEIGHT:    pll_weight_in = csr_wdata[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end

      rsp_data_in               = rsp_data_ff;
      if (advance) begin
         rsp_data_in.pulse_96th    = pulse_96th;
         rsp_data_in.pulse_16th    = pulse_16th;
         rsp_data_in.send_valid    = send_valid;
         rsp_data_in.send_byte     = send_byte;
         rsp_data_in.run_status    = run_state_in;
         rsp_data_in.beat_interval = interval_in;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_mode_ff <= '0;
         tx_enable_ff  <= 1'b0;
         pll_weight_ff <= WEIGHT_RESET;
         run_state_ff  <= RUN_PAUSED;
         countdown_ff  <= '0;
         last_stamp_ff <= '0;
         interval_ff   <= BASE_RESET;
         out_count_ff  <= '0;
         in_count_ff   <= '0;
         stg_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clock_mode_ff <= clock_mode_in;
         tx_enable_ff  <= tx_enable_in;
         pll_weight_ff <= pll_weight_in;
         run_state_ff  <= run_state_in;
         countdown_ff  <= countdown_in;
         last_stamp_ff <= last_stamp_in;
         interval_ff   <= interval_in;
         out_count_ff  <= out_count_in;
         in_count_ff   <= in_count_in;
         stg_valid_ff  <= stg_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      stg_data_ff <= stg_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A running countdown steps down by exactly one per tick beat.
   a_countdown_step: assert property (@(posedge clock) disable iff (reset)
      advance && stg_data_ff.command == CMD_TICK && countdown_ff != '0
      |=> countdown_ff == $past(countdown_ff) - STAMP_W'(1))
      else $error("countdown did not step down by one");

   // A 16th pulse only ever rides on a 96th pulse.
   a_16th_on_96th: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pulse_16th |-> rsp_data_ff.pulse_96th)
      else $error("16th pulse without 96th pulse");

   // A sent byte only comes out of internal mode with transmit on.
   a_send_gated: assert property (@(posedge clock) disable iff (reset)
      advance && send_valid |-> int_mode && tx_enable_ff)
      else $error("MIDI byte sent outside internal transmit");

   // Input is held off only while the stage is occupied and blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stg_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

endmodule

`default_nettype wire
